@@ hw/rtl/ums_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ums_pkg
// Shared types and constants of the USB MIDI descriptor scanner.
// ----------------------------------------------------------------------------
package ums_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH_CLASS    = 2'd0;
  localparam logic [1:0] REG_MATCH_SUBCLASS = 2'd1;
  localparam logic [1:0] REG_SIZE_LIMIT     = 2'd2;
  localparam logic [1:0] REG_SIZE_REPL      = 2'd3;

  localparam logic [7:0]  RST_MATCH_CLASS    = 8'h01;
  localparam logic [7:0]  RST_MATCH_SUBCLASS = 8'h03;
  localparam logic [15:0] RST_SIZE_LIMIT     = 16'd128;
  localparam logic [15:0] RST_SIZE_REPL      = 16'd64;

  // Descriptor type codes.
  localparam logic [7:0] DT_INTERFACE = 8'h04;
  localparam logic [7:0] DT_ENDPOINT  = 8'h05;

  localparam logic [7:0] NO_INTERFACE = 8'hFF;

  // Depth of the queue between the scanner and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]  match_class;
    logic [7:0]  match_subclass;
    logic [15:0] size_limit;
    logic [15:0] size_repl;
  } cfg_t;

  typedef struct packed {
    logic       found;
    logic [7:0] iface;
    logic [7:0] alt;
    logic [7:0] in_ep;
    logic       in_found;
    logic [7:0] out_ep;
    logic       out_found;
  } summary_t;

  // One queue entry: an optional leading word plus the main word.
  typedef struct packed {
    logic       pre_valid;
    logic [7:0] pre_byte;
    logic [7:0] main_byte;
    logic       done;
    logic       bad;
    summary_t   summary;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/usb_midi_descriptor_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_midi_descriptor_scanner
// Passes a USB configuration descriptor set through, finds the MIDI streaming
// interface and its endpoints, and clamps oversized endpoint packet sizes.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the s_ stream, one word per byte; s_tuser marks the first
// byte of a new set. Every byte leaves on the m_ stream, possibly rewritten;
// m_tlast marks the last byte of the set, which also carries the summary in
// the upper tdata bits, and m_tuser flags a zero descriptor length.
// The input takes one byte per cycle unless the queue is full. Each result
// word is registered in the queue when its byte is accepted; the output
// gives one word per cycle while m_tready is high. A max packet size's low
// byte in a matching interface gives no word; its high byte gives low and high.
// A four-entry queue separates the scanner from the output stage, so the
// input keeps flowing while the receiver stalls until that queue fills.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset (rst, synchronous) empties the queue, stops the scan and loads the
// register defaults: class 1, subclass 3, limit 128, replacement 64.
// ----------------------------------------------------------------------------
module usb_midi_descriptor_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] start_req
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] out_byte, [8] found, [16:9] interface_number,
  // [24:17] alternate_setting, [32:25] in_endpoint, [33] in_found,
  // [41:34] out_endpoint, [42] out_found, [47:43] zero
  output logic [47:0]      m_tdata,
  output logic             m_tlast,   // done_res
  output logic [0:0]       m_tuser,   // [0] malformed
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ums_pkg::cfg_t   cfg;
  ums_pkg::entry_t entry;
  ums_pkg::entry_t head;
  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_class    <= ums_pkg::RST_MATCH_CLASS;
      cfg.match_subclass <= ums_pkg::RST_MATCH_SUBCLASS;
      cfg.size_limit     <= ums_pkg::RST_SIZE_LIMIT;
      cfg.size_repl      <= ums_pkg::RST_SIZE_REPL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ums_pkg::REG_MATCH_CLASS:    cfg.match_class    <= cfg_data[7:0];
        ums_pkg::REG_MATCH_SUBCLASS: cfg.match_subclass <= cfg_data[7:0];
        ums_pkg::REG_SIZE_LIMIT:     cfg.size_limit     <= cfg_data;
        ums_pkg::REG_SIZE_REPL:      cfg.size_repl      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  ums_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (s_tdata),
    .start_req (s_tuser[0]),
    .entry     (entry),
    .push      (push)
  );

  ums_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  ums_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
`default_nettype wire

@@ hw/rtl/ums_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ums_front
// Scanner: walks the descriptor set, tracks matches and builds queue entries.
// ----------------------------------------------------------------------------
module ums_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ums_pkg::cfg_t  cfg,
  input  wire logic           accept,
  input  wire logic [7:0]     data_byte,
  input  wire logic           start_req,
  output ums_pkg::entry_t     entry,
  output logic                push
);

  logic        scan_active, scan_active_next;
  logic [15:0] set_offset, set_offset_next;
  logic [15:0] total_length, total_length_next;
  logic [7:0]  bid, bid_next;
  logic [7:0]  dlen, dlen_next;
  logic [7:0]  dtype, dtype_next;
  logic        inside_match, inside_match_next;
  logic [7:0]  cur_if, cur_if_next;
  logic [7:0]  cur_alt, cur_alt_next;
  logic [7:0]  cur_class, cur_class_next;
  logic [7:0]  held_low, held_low_next;
  ums_pkg::summary_t summary, summary_next;

  logic        holding;
  logic        hold;
  logic        bad;
  logic        is_last;
  logic        end_scan;
  logic [7:0]  step;
  logic [15:0] size;
  logic [7:0]  out_b;

  assign holding = scan_active && dtype == ums_pkg::DT_ENDPOINT && inside_match &&
                   bid == 8'd5 && dlen >= 8'd6;

  always_comb begin
    scan_active_next  = scan_active;
    set_offset_next   = set_offset;
    total_length_next = total_length;
    bid_next          = bid;
    dlen_next         = dlen;
    dtype_next        = dtype;
    inside_match_next = inside_match;
    cur_if_next       = cur_if;
    cur_alt_next      = cur_alt;
    cur_class_next    = cur_class;
    held_low_next     = held_low;
    summary_next      = summary;
    entry.pre_valid   = 1'b0;
    entry.pre_byte    = held_low;
    hold              = 1'b0;
    bad               = 1'b0;
    is_last           = 1'b0;
    end_scan          = 1'b0;
    out_b             = data_byte;
    size              = 16'd0;
    step              = 8'd0;

    // A start flushes a held low byte unchanged, then restarts the scan.
    if (start_req) begin
      entry.pre_valid   = holding;
      scan_active_next  = 1'b1;
      set_offset_next   = 16'd0;
      total_length_next = 16'd0;
      bid_next          = 8'd0;
      dlen_next         = 8'd0;
      dtype_next        = 8'd0;
      inside_match_next = 1'b0;
      cur_if_next       = ums_pkg::NO_INTERFACE;
      cur_alt_next      = 8'd0;
      cur_class_next    = 8'd0;
      held_low_next     = 8'd0;
      summary_next      = '0;
      summary_next.iface = ums_pkg::NO_INTERFACE;
    end

    if (scan_active_next) begin
      if (set_offset_next == 16'd2) total_length_next[7:0] = data_byte;
      if (set_offset_next == 16'd3) total_length_next[15:8] = data_byte;
      is_last = set_offset_next >= 16'd3 &&
                ({1'b0, set_offset_next} + 17'd1) >= {1'b0, total_length_next};

      if (bid_next == 8'd0) begin
        dlen_next  = data_byte;
        dtype_next = 8'd0;
        bad        = data_byte == 8'd0;
      end else if (bid_next == 8'd1) begin
        dtype_next = data_byte;
        if (data_byte == ums_pkg::DT_INTERFACE) inside_match_next = 1'b0;
      end else if (dtype_next == ums_pkg::DT_INTERFACE) begin
        if (bid_next == 8'd2) cur_if_next = data_byte;
        else if (bid_next == 8'd3) cur_alt_next = data_byte;
        else if (bid_next == 8'd5) cur_class_next = data_byte;
        else if (bid_next == 8'd6 && cur_class_next == cfg.match_class &&
                 data_byte == cfg.match_subclass) begin
          inside_match_next  = 1'b1;
          summary_next.found = 1'b1;
          summary_next.iface = cur_if_next;
          summary_next.alt   = cur_alt_next;
        end
      end else if (dtype_next == ums_pkg::DT_ENDPOINT && inside_match_next) begin
        if (bid_next == 8'd2) begin
          if (data_byte[7]) begin
            summary_next.in_ep    = data_byte;
            summary_next.in_found = 1'b1;
          end else begin
            summary_next.out_ep    = data_byte;
            summary_next.out_found = 1'b1;
          end
        end else if (bid_next == 8'd4 && dlen_next >= 8'd6 && !is_last) begin
          hold          = 1'b1;
          held_low_next = data_byte;
        end else if (bid_next == 8'd5 && dlen_next >= 8'd6) begin
          size = {data_byte, held_low_next};
          if (size > cfg.size_limit) size = cfg.size_repl;
          entry.pre_valid = 1'b1;
          entry.pre_byte  = size[7:0];
          out_b           = size[15:8];
        end
      end

      set_offset_next = set_offset_next + 16'd1;
      if (hold) begin
        bid_next = 8'd5;
      end else begin
        step             = bid_next + 8'd1;
        bid_next         = (step >= dlen_next) ? 8'd0 : step;
        end_scan         = is_last || bad;
        scan_active_next = !end_scan;
      end
    end

    entry.main_byte = out_b;
    entry.done      = end_scan;
    entry.bad       = bad;
    entry.summary   = summary_next;
    push            = accept && !hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active       <= 1'b0;
      set_offset        <= 16'd0;
      total_length      <= 16'd0;
      bid               <= 8'd0;
      dlen              <= 8'd0;
      dtype             <= 8'd0;
      inside_match      <= 1'b0;
      cur_if            <= ums_pkg::NO_INTERFACE;
      cur_alt           <= 8'd0;
      cur_class         <= 8'd0;
      held_low          <= 8'd0;
      summary.found     <= 1'b0;
      summary.iface     <= ums_pkg::NO_INTERFACE;
      summary.alt       <= 8'd0;
      summary.in_ep     <= 8'd0;
      summary.in_found  <= 1'b0;
      summary.out_ep    <= 8'd0;
      summary.out_found <= 1'b0;
    end else if (accept) begin
      scan_active  <= scan_active_next;
      set_offset   <= set_offset_next;
      total_length <= total_length_next;
      bid          <= bid_next;
      dlen         <= dlen_next;
      dtype        <= dtype_next;
      inside_match <= inside_match_next;
      cur_if       <= cur_if_next;
      cur_alt      <= cur_alt_next;
      cur_class    <= cur_class_next;
      held_low     <= held_low_next;
      summary      <= summary_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ums_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ums_queue
// Short entry queue between the scanner and the output stage.
// ----------------------------------------------------------------------------
module ums_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ums_pkg::entry_t push_entry,
  output logic                 full,
  input  wire logic            pop,
  output ums_pkg::entry_t      head,
  output logic                 head_valid
);

  ums_pkg::entry_t mem [ums_pkg::QUEUE_DEPTH];
  logic [ums_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ums_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ums_pkg::QUEUE_AW:0]   count;

  assign full       = count == (ums_pkg::QUEUE_AW+1)'(ums_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + (ums_pkg::QUEUE_AW)'(1);
      if (pop) rd_ptr <= rd_ptr + (ums_pkg::QUEUE_AW)'(1);
      if (push && !pop) count <= count + (ums_pkg::QUEUE_AW+1)'(1);
      else if (pop && !push) count <= count - (ums_pkg::QUEUE_AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ums_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ums_back
// Output stage: expands each queue entry into one or two output words.
// ----------------------------------------------------------------------------
module ums_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ums_pkg::entry_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [47:0]          m_tdata,
  output logic                 m_tlast,
  output logic [0:0]           m_tuser
);

  // Set once the leading word of a two-word entry has gone out.
  logic second;
  logic main_now;
  logic done;

  assign main_now = !head.pre_valid || second;
  assign done     = main_now && head.done;
  assign m_tvalid = head_valid;
  assign pop      = head_valid && m_tready && main_now;

  always_comb begin
    m_tdata       = '0;
    m_tdata[7:0]  = main_now ? head.main_byte : head.pre_byte;
    if (done) begin
      m_tdata[8]     = head.summary.found;
      m_tdata[16:9]  = head.summary.iface;
      m_tdata[24:17] = head.summary.alt;
      m_tdata[32:25] = head.summary.in_ep;
      m_tdata[33]    = head.summary.in_found;
      m_tdata[41:34] = head.summary.out_ep;
      m_tdata[42]    = head.summary.out_found;
    end
    m_tlast    = done;
    m_tuser[0] = done && head.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (head_valid && m_tready) begin
      second <= !main_now;
    end
  end

endmodule
`default_nettype wire
